// ----- hdl/qrs_pkg.sv -----
// Shared types, constants and helpers for the quadratic root solver.
package qrs_pkg;

  localparam int unsigned COEF_W     = 16;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned RAD_W      = 64;
  localparam int unsigned SQRT_CELLS = RAD_W / 2;
  localparam int unsigned SREM_W     = SQRT_CELLS + 2;
  localparam int unsigned NUM_W      = 34;
  localparam int unsigned MAG_W      = NUM_W - 1;
  localparam int unsigned DIV_CELLS  = MAG_W;
  localparam int unsigned LATENCY    = 2 + SQRT_CELLS + 1 + DIV_CELLS + 1;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ONE   = 2'd1,
    KIND_TWO   = 2'd2,
    KIND_DEGEN = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    MODE_DEG  = 3'd0,
    MODE_LIN  = 3'd1,
    MODE_ZERO = 3'd2,
    MODE_NONE = 3'd3,
    MODE_SYM  = 3'd4,
    MODE_CZ   = 3'd5,
    MODE_GEN1 = 3'd6,
    MODE_GEN2 = 3'd7
  } mode_e;

  typedef struct packed {
    mode_e                   mode;
    logic signed [NUM_W-1:0] base;
    logic                    den_neg;
    logic [COEF_W-1:0]       den_mag;
  } smeta_t;

  typedef struct packed {
    mode_e mode;
    logic  neg1;
    logic  neg2;
  } dmeta_t;

  typedef struct packed {
    logic              sat;
    logic [ROOT_W-1:0] val;
  } clip_t;

  function automatic clip_t clip_root(input logic signed [NUM_W-1:0] v);
    clip_t r;
    r.sat = 1'b0;
    r.val = v[ROOT_W-1:0];
    if (v > $signed({{(NUM_W-ROOT_W+1){1'b0}}, {(ROOT_W-1){1'b1}}})) begin
      r.sat = 1'b1;
      r.val = {1'b0, {(ROOT_W-1){1'b1}}};
    end else if (v < $signed({{(NUM_W-ROOT_W+1){1'b1}}, {(ROOT_W-1){1'b0}}})) begin
      r.sat = 1'b1;
      r.val = {1'b1, {(ROOT_W-1){1'b0}}};
    end
    return r;
  endfunction

endpackage

// ----- hdl/qrs_front.sv -----
// Front stages: coefficient products, case decode, radicand and numerator base.
module qrs_front import qrs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic signed [COEF_W-1:0] coef_a_i,
  input  logic signed [COEF_W-1:0] coef_b_i,
  input  logic signed [COEF_W-1:0] coef_c_i,
  output logic                     valid_o,
  output logic [RAD_W-1:0]         rad_o,
  output smeta_t                   meta_o
);

  logic                     v1_q;
  logic signed [COEF_W-1:0] a_q, b_q, c_q;
  logic [2*COEF_W-1:0]      bb_q;
  logic signed [2*COEF_W-1:0] ac_q;
  logic [2*COEF_W-1:0]      acm_q;

  logic [COEF_W-1:0] am, cm;
  assign am = coef_a_i[COEF_W-1] ? COEF_W'(-coef_a_i) : coef_a_i;
  assign cm = coef_c_i[COEF_W-1] ? COEF_W'(-coef_c_i) : coef_c_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= coef_a_i;
    b_q   <= coef_b_i;
    c_q   <= coef_c_i;
    bb_q  <= (2*COEF_W)'(coef_b_i) * (2*COEF_W)'(coef_b_i);
    ac_q  <= coef_a_i * coef_c_i;
    acm_q <= am * cm;
  end

  logic signed [NUM_W-1:0] d, b_ext, c_ext;
  logic                    az, bz, cz;
  logic                    rv_q;
  logic [RAD_W-1:0]        rad_d;
  smeta_t                  meta_d;

  always_comb begin
    d     = $signed({2'b00, bb_q}) - $signed({ac_q, 2'b00});
    b_ext = NUM_W'(b_q);
    c_ext = NUM_W'(c_q);
    az    = (a_q == '0);
    bz    = (b_q == '0);
    cz    = (c_q == '0);
    rad_d = '0;
    meta_d.base    = '0;
    meta_d.den_neg = a_q[COEF_W-1];
    meta_d.den_mag = a_q[COEF_W-1] ? COEF_W'(-a_q) : a_q;
    if (az && bz) begin
      meta_d.mode = MODE_DEG;
    end else if (az) begin
      meta_d.mode    = MODE_LIN;
      meta_d.base    = -(c_ext <<< 16);
      meta_d.den_neg = b_q[COEF_W-1];
      meta_d.den_mag = b_q[COEF_W-1] ? COEF_W'(-b_q) : b_q;
    end else if (bz && cz) begin
      meta_d.mode = MODE_ZERO;
    end else if (bz) begin
      meta_d.den_neg = 1'b0;
      if (c_q[COEF_W-1] == a_q[COEF_W-1]) begin
        meta_d.mode = MODE_NONE;
      end else begin
        meta_d.mode = MODE_SYM;
        rad_d       = {acm_q, {(RAD_W-2*COEF_W){1'b0}}};
      end
    end else if (cz) begin
      meta_d.mode = MODE_CZ;
      meta_d.base = -(b_ext <<< 16);
    end else if (d[NUM_W-1]) begin
      meta_d.mode = MODE_NONE;
    end else begin
      meta_d.mode = (d == '0) ? MODE_GEN1 : MODE_GEN2;
      meta_d.base = -(b_ext <<< 15);
      rad_d       = {{(RAD_W-NUM_W-16){1'b0}}, d, 16'h0000};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_o  <= rad_d;
    meta_o <= meta_d;
  end

  assign valid_o = rv_q;

endmodule

// ----- hdl/qrs_sqrt_cell.sv -----
// One square root cell: retires one root bit per stage.
module qrs_sqrt_cell import qrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [SREM_W-1:0] rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  smeta_t            meta_i,
  output logic              valid_o,
  output logic [RAD_W-1:0]  rad_o,
  output logic [SREM_W-1:0] rem_o,
  output logic [ROOT_W-1:0] root_o,
  output smeta_t            meta_o
);

  logic [SREM_W+1:0] cur, trial;
  logic              ge;

  assign cur   = {rem_i, rad_i[RAD_W-1 -: 2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign ge    = (cur >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_o  <= {rad_i[RAD_W-3:0], 2'b00};
    rem_o  <= ge ? SREM_W'(cur - trial) : SREM_W'(cur);
    root_o <= {root_i[ROOT_W-2:0], ge};
    meta_o <= meta_i;
  end

endmodule

// ----- hdl/qrs_div_cell.sv -----
// One divider cell: retires one quotient bit per stage for both roots.
module qrs_div_cell import qrs_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [1:0][MAG_W-1:0]       num_i,
  input  logic [1:0][COEF_W-1:0]      rem_i,
  input  logic [1:0][MAG_W-1:0]       quo_i,
  input  logic [COEF_W-1:0]           den_i,
  input  dmeta_t                      meta_i,
  output logic                        valid_o,
  output logic [1:0][MAG_W-1:0]       num_o,
  output logic [1:0][COEF_W-1:0]      rem_o,
  output logic [1:0][MAG_W-1:0]       quo_o,
  output logic [COEF_W-1:0]           den_o,
  output dmeta_t                      meta_o
);

  logic [1:0][COEF_W:0]  cur;
  logic [1:0]            ge;
  logic [1:0][COEF_W-1:0] rem_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      cur[l]   = {rem_i[l], num_i[l][MAG_W-1]};
      ge[l]    = (cur[l] >= {1'b0, den_i});
      rem_d[l] = ge[l] ? COEF_W'(cur[l] - {1'b0, den_i}) : cur[l][COEF_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      num_o[l] <= {num_i[l][MAG_W-2:0], 1'b0};
      quo_o[l] <= {quo_i[l][MAG_W-2:0], ge[l]};
    end
    rem_o  <= rem_d;
    den_o  <= den_i;
    meta_o <= meta_i;
  end

endmodule

// ----- hdl/quadratic_root_solver.sv -----
// Top level of the quadratic root solver: front stages, root and divider cell rows.
// Fully pipelined: a coefficient word can start every cycle and busy_o stays low.
// Each result appears on the done_o strobe after its start has passed through
// two front stages, 32 square-root cells, a numerator stage, 33 divider cells
// and the output register. The receiver cannot stall, so results must be taken
// in the cycle they are shown.
module quadratic_root_solver import qrs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [COEF_W-1:0] coef_a_i,
  input  logic signed [COEF_W-1:0] coef_b_i,
  input  logic signed [COEF_W-1:0] coef_c_i,
  output logic                     done_o,
  output logic [1:0]               root_kind_o,
  output logic signed [ROOT_W-1:0] first_root_o,
  output logic signed [ROOT_W-1:0] second_root_o,
  output logic                     saturated_o
);

  logic              sv [SQRT_CELLS+1];
  logic [RAD_W-1:0]  srad [SQRT_CELLS+1];
  logic [SREM_W-1:0] srem [SQRT_CELLS+1];
  logic [ROOT_W-1:0] sroot [SQRT_CELLS+1];
  smeta_t            smeta [SQRT_CELLS+1];

  assign busy_o = 1'b0;

  qrs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i),
    .coef_a_i (coef_a_i),
    .coef_b_i (coef_b_i),
    .coef_c_i (coef_c_i),
    .valid_o  (sv[0]),
    .rad_o    (srad[0]),
    .meta_o   (smeta[0])
  );

  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sv[i]),
      .rad_i   (srad[i]),
      .rem_i   (srem[i]),
      .root_i  (sroot[i]),
      .meta_i  (smeta[i]),
      .valid_o (sv[i+1]),
      .rad_o   (srad[i+1]),
      .rem_o   (srem[i+1]),
      .root_o  (sroot[i+1]),
      .meta_o  (smeta[i+1])
    );
  end

  smeta_t                  sm;
  logic signed [NUM_W-1:0] s_ext, s7, n1, n2;
  logic [1:0][MAG_W-1:0]   mag_d;
  dmeta_t                  dm_d;

  always_comb begin
    sm    = smeta[SQRT_CELLS];
    s_ext = $signed({{(NUM_W-ROOT_W){1'b0}}, sroot[SQRT_CELLS]});
    s7    = s_ext <<< 7;
    unique case (sm.mode)
      MODE_GEN1, MODE_GEN2: begin
        n1 = sm.base - s7;
        n2 = sm.base + s7;
      end
      MODE_LIN: begin
        n1 = sm.base;
        n2 = sm.base;
      end
      MODE_CZ: begin
        n1 = '0;
        n2 = sm.base;
      end
      MODE_SYM: begin
        n1 = s_ext;
        n2 = -s_ext;
      end
      default: begin
        n1 = '0;
        n2 = '0;
      end
    endcase
    mag_d[0]  = n1[NUM_W-1] ? MAG_W'(-n1) : n1[MAG_W-1:0];
    mag_d[1]  = n2[NUM_W-1] ? MAG_W'(-n2) : n2[MAG_W-1:0];
    dm_d.mode = sm.mode;
    dm_d.neg1 = n1[NUM_W-1] ^ sm.den_neg;
    dm_d.neg2 = n2[NUM_W-1] ^ sm.den_neg;
  end

  logic                   dv [DIV_CELLS+1];
  logic [1:0][MAG_W-1:0]  dnum [DIV_CELLS+1];
  logic [1:0][COEF_W-1:0] drem [DIV_CELLS+1];
  logic [1:0][MAG_W-1:0]  dquo [DIV_CELLS+1];
  logic [COEF_W-1:0]      dden [DIV_CELLS+1];
  dmeta_t                 dmeta [DIV_CELLS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= sv[SQRT_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    dnum[0]  <= mag_d;
    dden[0]  <= sm.den_mag;
    dmeta[0] <= dm_d;
  end

  assign drem[0] = '0;
  assign dquo[0] = '0;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    qrs_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[i]),
      .num_i   (dnum[i]),
      .rem_i   (drem[i]),
      .quo_i   (dquo[i]),
      .den_i   (dden[i]),
      .meta_i  (dmeta[i]),
      .valid_o (dv[i+1]),
      .num_o   (dnum[i+1]),
      .rem_o   (drem[i+1]),
      .quo_o   (dquo[i+1]),
      .den_o   (dden[i+1]),
      .meta_o  (dmeta[i+1])
    );
  end

  dmeta_t                  om;
  logic signed [NUM_W-1:0] v1, v2;
  clip_t                   c1, c2;
  kind_e                   kind_d;
  logic [ROOT_W-1:0]       x1_d, x2_d;
  logic                    sat_d;
  logic                    done_q;
  logic [1:0]              kind_q;
  logic [ROOT_W-1:0]       x1_q, x2_q;
  logic                    sat_q;

  always_comb begin
    om    = dmeta[DIV_CELLS];
    v1    = om.neg1 ? -$signed({1'b0, dquo[DIV_CELLS][0]})
                    :  $signed({1'b0, dquo[DIV_CELLS][0]});
    v2    = om.neg2 ? -$signed({1'b0, dquo[DIV_CELLS][1]})
                    :  $signed({1'b0, dquo[DIV_CELLS][1]});
    c1    = clip_root(v1);
    c2    = clip_root(v2);
    x1_d  = c1.val;
    x2_d  = c2.val;
    sat_d = c1.sat | c2.sat;
    unique case (om.mode)
      MODE_DEG:             kind_d = KIND_DEGEN;
      MODE_NONE:            kind_d = KIND_NONE;
      MODE_ZERO:            kind_d = KIND_ONE;
      MODE_LIN, MODE_GEN1:  kind_d = KIND_ONE;
      default:              kind_d = KIND_TWO;
    endcase
    if (om.mode == MODE_DEG || om.mode == MODE_NONE || om.mode == MODE_ZERO) begin
      x1_d  = '0;
      x2_d  = '0;
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv[DIV_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    x1_q   <= x1_d;
    x2_q   <= x2_d;
    sat_q  <= sat_d;
  end

  assign done_o        = done_q;
  assign root_kind_o   = kind_q;
  assign first_root_o  = x1_q;
  assign second_root_o = x2_q;
  assign saturated_o   = sat_q;

endmodule

// ----- hdl/qrs_checker.sv -----
// Port-level checks for the quadratic root solver, bound to the top level.
module qrs_checker import qrs_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic                     done_o,
  input logic [1:0]               root_kind_o,
  input logic signed [ROOT_W-1:0] first_root_o,
  input logic signed [ROOT_W-1:0] second_root_o,
  input logic                     saturated_o
);

  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result word without a start");

  a_start_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("start word without a result");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (root_kind_o == KIND_NONE || root_kind_o == KIND_DEGEN)) |->
      (first_root_o == '0 && second_root_o == '0 && !saturated_o))
    else $error("rootless result carries data");

  a_one_root_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && root_kind_o == KIND_ONE) |-> (first_root_o == second_root_o))
    else $error("single root differs between outputs");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .root_kind_o   (root_kind_o),
  .first_root_o  (first_root_o),
  .second_root_o (second_root_o),
  .saturated_o   (saturated_o)
);

// ----- bench/quadratic_root_solver_tb.sv -----
// Testbench for quadratic_root_solver: directed table, random words, predicted results.
`timescale 1ns / 100ps

module quadratic_root_solver_tb;
  import qrs_pkg::*;

  typedef struct {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic                     known;
    kind_e                    kind;
    logic signed [ROOT_W-1:0] x1;
    logic signed [ROOT_W-1:0] x2;
    logic                     sat;
  } row_t;

  typedef struct packed {
    kind_e                    kind;
    logic signed [ROOT_W-1:0] x1;
    logic signed [ROOT_W-1:0] x2;
    logic                     sat;
  } roots_t;

  localparam int WATCHDOG = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [COEF_W-1:0] coef_a_i = '0;
  logic signed [COEF_W-1:0] coef_b_i = '0;
  logic signed [COEF_W-1:0] coef_c_i = '0;
  logic busy_o, done_o, saturated_o;
  logic [1:0] root_kind_o;
  logic signed [ROOT_W-1:0] first_root_o, second_root_o;

  roots_t pending_roots[$];
  int errors = 0;
  int idle_cycles = 0;
  int words_sent = 0;
  int results_seen = 0;
  int sender_idle_pct = 0;
  int kind_count[4] = '{0, 0, 0, 0};

  quadratic_root_solver DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint clip(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic roots_t solve_quadratic(input logic signed [COEF_W-1:0] ca,
                                             input logic signed [COEF_W-1:0] cb,
                                             input logic signed [COEF_W-1:0] cc);
    longint a, b, c, d, s, nb, r, x1, x2;
    logic [63:0] cm, am;
    logic sat;
    roots_t o;
    a = ca;
    b = cb;
    c = cc;
    x1 = 0;
    x2 = 0;
    sat = 1'b0;
    o.kind = KIND_NONE;
    if (a == 0 && b == 0) begin
      o.kind = KIND_DEGEN;
    end else if (a == 0) begin
      x1 = clip((-c * 65536) / b, sat);
      x2 = x1;
      o.kind = KIND_ONE;
    end else if (b == 0 && c == 0) begin
      o.kind = KIND_ONE;
    end else if (b == 0) begin
      if ((c < 0) != (a < 0)) begin
        cm = (c < 0) ? -c : c;
        am = (a < 0) ? -a : a;
        r = isqrt((cm << 32) / am);
        x1 = clip(r, sat);
        x2 = clip(-r, sat);
        o.kind = KIND_TWO;
      end
    end else if (c == 0) begin
      x2 = clip((-b * 65536) / a, sat);
      o.kind = KIND_TWO;
    end else begin
      d = b * b - 4 * a * c;
      if (d >= 0) begin
        s = isqrt(d * 65536);
        nb = -b * 256;
        if (d == 0) begin
          x1 = clip((nb * 128) / a, sat);
          x2 = x1;
          o.kind = KIND_ONE;
        end else begin
          x1 = clip(((nb - s) * 128) / a, sat);
          x2 = clip(((nb + s) * 128) / a, sat);
          o.kind = KIND_TWO;
        end
      end
    end
    o.x1 = x1[ROOT_W-1:0];
    o.x2 = x2[ROOT_W-1:0];
    o.sat = sat;
    return o;
  endfunction

  // Directed rows: known results only where obvious.
  row_t directed[] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1, KIND_DEGEN, 0, 0, 0},
    '{16'sd0, 16'sd0, 16'sh7fff, 1, KIND_DEGEN, 0, 0, 0},
    '{16'sd0, 16'sd0, 16'sh8000, 1, KIND_DEGEN, 0, 0, 0},
    '{16'sd0, 16'sd256, 16'sd256, 1, KIND_ONE, -32'sd65536, -32'sd65536, 0},
    '{16'sd0, 16'sd1, 16'sh7fff, 1, KIND_ONE, 32'sh80010000, 32'sh80010000, 0},
    '{16'sd0, 16'sh8000, 16'sh8000, 0, KIND_NONE, 0, 0, 0},
    '{16'sd0, 16'sd1, 16'sh8000, 1, KIND_ONE, 32'sh7fffffff, 32'sh7fffffff, 1},
    '{16'sd256, 16'sd0, 16'sd0, 1, KIND_ONE, 0, 0, 0},
    '{16'sh8000, 16'sd0, 16'sd0, 1, KIND_ONE, 0, 0, 0},
    '{16'sd256, 16'sd0, 16'sd256, 1, KIND_NONE, 0, 0, 0},
    '{16'sh8000, 16'sd0, 16'sh8000, 1, KIND_NONE, 0, 0, 0},
    '{16'sd256, 16'sd0, -16'sd1024, 1, KIND_TWO, 32'sd131072, -32'sd131072, 0},
    '{16'sd1, 16'sd0, 16'sh8000, 0, KIND_NONE, 0, 0, 0},
    '{16'sh7fff, 16'sd0, -16'sd1, 0, KIND_NONE, 0, 0, 0},
    '{16'sd256, 16'sd512, 16'sd0, 1, KIND_TWO, 0, -32'sd131072, 0},
    '{16'sd1, 16'sh8000, 16'sd0, 0, KIND_NONE, 0, 0, 0},
    '{16'sh8000, 16'sh7fff, 16'sd0, 0, KIND_NONE, 0, 0, 0},
    '{16'sd256, 16'sd512, 16'sd256, 1, KIND_ONE, -32'sd65536, -32'sd65536, 0},
    '{16'sd256, 16'sd256, 16'sd256, 1, KIND_NONE, 0, 0, 0},
    '{16'sd256, 16'sd0 - 16'sd768, 16'sd512, 1, KIND_TWO, 32'sd65536, 32'sd131072, 0},
    '{16'sd1, 16'sh7fff, 16'sd1, 0, KIND_NONE, 0, 0, 0},
    '{16'sh8000, 16'sh8000, 16'sh8000, 0, KIND_NONE, 0, 0, 0},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 0, KIND_NONE, 0, 0, 0},
    '{16'sh8000, 16'sh8000, 16'sh7fff, 0, KIND_NONE, 0, 0, 0},
    '{-16'sd1, 16'sd1, 16'sh7fff, 0, KIND_NONE, 0, 0, 0}
  };

  task automatic send_word(input logic signed [COEF_W-1:0] a,
                           input logic signed [COEF_W-1:0] b,
                           input logic signed [COEF_W-1:0] c,
                           input logic known, input roots_t typed);
    roots_t pred;
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    coef_a_i <= a;
    coef_b_i <= b;
    coef_c_i <= c;
    pred = solve_quadratic(a, b, c);
    if (known && pred != typed) begin
      $display("%0t table row a=%0d b=%0d c=%0d: expected %p, predictor %p",
               $time, a, b, c, typed, pred);
      errors++;
    end
    do @(posedge clk_i); while (busy_o);
    pending_roots.push_back(known ? typed : pred);
    words_sent++;
  endtask

  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(7))
      0: return '0;
      1: return 16'sh7fff;
      2: return 16'sh8000;
      3, 4: return $signed(16'($urandom_range(2047))) - 16'sd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    roots_t want;
    if (rst_ni) begin
      if (done_o) begin
        results_seen++;
        idle_cycles <= 0;
        if (pending_roots.size() == 0) begin
          $display("%0t unexpected result kind=%0d x1=%0d x2=%0d sat=%0b", $time,
                   root_kind_o, first_root_o, second_root_o, saturated_o);
          errors++;
        end else begin
          want = pending_roots.pop_front();
          kind_count[root_kind_o]++;
          if (root_kind_o !== want.kind) begin
            $display("%0t root_kind expected %0d actual %0d", $time, want.kind, root_kind_o);
            errors++;
          end
          if (first_root_o !== want.x1) begin
            $display("%0t first_root expected %0d actual %0d", $time, want.x1, first_root_o);
            errors++;
          end
          if (second_root_o !== want.x2) begin
            $display("%0t second_root expected %0d actual %0d", $time, want.x2, second_root_o);
            errors++;
          end
          if (saturated_o !== want.sat) begin
            $display("%0t saturated expected %0b actual %0b", $time, want.sat, saturated_o);
            errors++;
          end
        end
      end else if (start_i && !busy_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    roots_t typed;
    int n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_idle_pct = 20;
    foreach (directed[i]) begin
      typed.kind = directed[i].kind;
      typed.x1 = directed[i].x1;
      typed.x2 = directed[i].x2;
      typed.sat = directed[i].sat;
      send_word(directed[i].a, directed[i].b, directed[i].c, directed[i].known, typed);
    end
    start_i <= 1'b0;
    // hold until the pipeline drains
    while (pending_roots.size() != 0) @(posedge clk_i);
    for (n = 0; n < 1080; n++) begin
      if (n == 360) sender_idle_pct = 45;
      if (n == 720) sender_idle_pct = 0;
      send_word(pick_coef(), pick_coef(), pick_coef(), 1'b0, typed);
    end
    start_i <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Sent %0d words, checked %0d results (none %0d, one %0d, two %0d, degen %0d).",
             words_sent, results_seen, kind_count[0], kind_count[1], kind_count[2],
             kind_count[3]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/qrs_pkg.sv
hdl/qrs_front.sv
hdl/qrs_sqrt_cell.sv
hdl/qrs_div_cell.sv
hdl/quadratic_root_solver.sv
hdl/qrs_checker.sv
bench/quadratic_root_solver_tb.sv
